// File: rtl/core/npcm_pkg.sv
// Package with the word types, codes and shared types of the nearest palette color match unit.
package npcm_pkg;

    // Width of the palette_count configuration register.
    localparam int CFG_W = 9;

    // Width of one palette entry: red, green, blue.
    localparam int ENTRY_W = 24;

    // Width of a squared distance, enough for three times 255 squared.
    localparam int DIST_W = 18;

    // Width of one squared color component difference.
    localparam int SQ_W = 16;

    // Codes of the kind field.
    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_QUANT = 1'b1;

    typedef struct packed {
        logic       kind;
        logic [7:0] entry_index;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } in_word_t;

    typedef struct packed {
        logic [7:0]        best_index;
        logic [DIST_W-1:0] best_distance;
    } out_word_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_DRAIN,
        ST_DELIVER
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic write;
        logic start;
        logic issue;
        logic load_result;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic last_issue;
        logic busy;
        logic out_busy;
    } status_t;

endpackage

// File: rtl/core/npcm_ctrl.sv
// Controller state machine that sequences palette writes and palette searches.
module npcm_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               s_kind,
    output logic               s_ready,
    input  npcm_pkg::status_t  status,
    output npcm_pkg::cmd_t     cmd
);

    npcm_pkg::state_t state_reg;
    npcm_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= npcm_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            npcm_pkg::ST_IDLE: begin
                if (s_valid && (s_kind == npcm_pkg::KIND_QUANT)) begin
                    state_next = npcm_pkg::ST_SEARCH;
                end
            end
            npcm_pkg::ST_SEARCH: begin
                if (status.last_issue) begin
                    state_next = npcm_pkg::ST_DRAIN;
                end
            end
            npcm_pkg::ST_DRAIN: begin
                if (!status.busy) begin
                    state_next = npcm_pkg::ST_DELIVER;
                end
            end
            npcm_pkg::ST_DELIVER: begin
                if (!status.out_busy) begin
                    state_next = npcm_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = npcm_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_ready         = 1'b0;
        cmd.write       = 1'b0;
        cmd.start       = 1'b0;
        cmd.issue       = 1'b0;
        cmd.load_result = 1'b0;
        unique case (state_reg)
            npcm_pkg::ST_IDLE: begin
                s_ready   = 1'b1;
                cmd.write = s_valid && (s_kind == npcm_pkg::KIND_WRITE);
                cmd.start = s_valid && (s_kind == npcm_pkg::KIND_QUANT);
            end
            npcm_pkg::ST_SEARCH: begin
                cmd.issue = 1'b1;
            end
            npcm_pkg::ST_DRAIN: begin
            end
            npcm_pkg::ST_DELIVER: begin
                cmd.load_result = !status.out_busy;
            end
            default: begin
            end
        endcase
    end

endmodule

// File: rtl/core/npcm_datapath.sv
// Datapath with the palette memory, distance pipeline, best-match tracker and result register.
module npcm_datapath #(
    parameter int PALETTE_DEPTH = 256
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  npcm_pkg::in_word_t                s_data,
    input  logic [npcm_pkg::CFG_W-1:0]        palette_count,
    input  npcm_pkg::cmd_t                    cmd,
    output npcm_pkg::status_t                 status,
    input  logic                              m_ready,
    output logic                              m_valid,
    output npcm_pkg::out_word_t               m_data
);

    localparam int IDX_W = $clog2(PALETTE_DEPTH);
    localparam logic [npcm_pkg::CFG_W-1:0] DEPTH_CFG = npcm_pkg::CFG_W'(PALETTE_DEPTH);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PALETTE_DEPTH - 1);

    logic [npcm_pkg::ENTRY_W-1:0] mem [PALETTE_DEPTH];

    logic                          wr_in_range;
    logic [IDX_W-1:0]              count_m1;

    logic [7:0]                    pix_r_reg;
    logic [7:0]                    pix_g_reg;
    logic [7:0]                    pix_b_reg;
    logic [IDX_W-1:0]              last_reg;
    logic [IDX_W-1:0]              rd_addr_reg;

    logic                          rd_v_reg;
    logic [IDX_W-1:0]              rd_idx_reg;
    logic [npcm_pkg::ENTRY_W-1:0]  rdata_reg;

    logic                          sq_v_reg;
    logic [IDX_W-1:0]              sq_idx_reg;
    logic [npcm_pkg::SQ_W-1:0]     sq_r_reg;
    logic [npcm_pkg::SQ_W-1:0]     sq_g_reg;
    logic [npcm_pkg::SQ_W-1:0]     sq_b_reg;
    logic [npcm_pkg::SQ_W-1:0]     sq_r_next;
    logic [npcm_pkg::SQ_W-1:0]     sq_g_next;
    logic [npcm_pkg::SQ_W-1:0]     sq_b_next;

    logic                          have_reg;
    logic [IDX_W-1:0]              best_idx_reg;
    logic [npcm_pkg::DIST_W-1:0]   best_dist_reg;
    logic [npcm_pkg::DIST_W-1:0]   dist_sum;

    logic                          m_valid_reg;
    npcm_pkg::out_word_t           m_data_reg;

    function automatic logic [npcm_pkg::SQ_W-1:0] sq_diff(input logic [7:0] a,
                                                         input logic [7:0] b);
        logic [7:0] d;
        d = (a >= b) ? (a - b) : (b - a);
        return npcm_pkg::SQ_W'(d) * npcm_pkg::SQ_W'(d);
    endfunction

    assign wr_in_range = {1'b0, s_data.entry_index} < DEPTH_CFG;

    // Searched range clamped to one entry at least and the palette depth at most.
    always_comb begin
        priority if (palette_count == '0) begin
            count_m1 = '0;
        end else if (palette_count > DEPTH_CFG) begin
            count_m1 = LAST_IDX;
        end else begin
            count_m1 = IDX_W'(palette_count - npcm_pkg::CFG_W'(1));
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.write && wr_in_range) begin
            mem[s_data.entry_index[IDX_W-1:0]] <= {s_data.red, s_data.green, s_data.blue};
        end
        if (cmd.issue) begin
            rdata_reg <= mem[rd_addr_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            pix_r_reg <= s_data.red;
            pix_g_reg <= s_data.green;
            pix_b_reg <= s_data.blue;
            last_reg  <= count_m1;
        end
        if (cmd.start) begin
            rd_addr_reg <= '0;
        end else if (cmd.issue) begin
            rd_addr_reg <= rd_addr_reg + IDX_W'(1);
        end
        rd_idx_reg <= rd_addr_reg;
        sq_idx_reg <= rd_idx_reg;
        sq_r_reg   <= sq_r_next;
        sq_g_reg   <= sq_g_next;
        sq_b_reg   <= sq_b_next;
    end

    assign sq_r_next = sq_diff(pix_r_reg, rdata_reg[23:16]);
    assign sq_g_next = sq_diff(pix_g_reg, rdata_reg[15:8]);
    assign sq_b_next = sq_diff(pix_b_reg, rdata_reg[7:0]);

    assign dist_sum = npcm_pkg::DIST_W'(sq_r_reg) + npcm_pkg::DIST_W'(sq_g_reg)
                    + npcm_pkg::DIST_W'(sq_b_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_v_reg <= 1'b0;
            sq_v_reg <= 1'b0;
            have_reg <= 1'b0;
        end else begin
            rd_v_reg <= cmd.issue;
            sq_v_reg <= rd_v_reg;
            if (cmd.start) begin
                have_reg <= 1'b0;
            end else if (sq_v_reg) begin
                have_reg <= 1'b1;
            end
        end
    end

    // Strict less-than keeps the lowest index on equal distances.
    always_ff @(posedge aclk) begin
        if (sq_v_reg && (!have_reg || (dist_sum < best_dist_reg))) begin
            best_dist_reg <= dist_sum;
            best_idx_reg  <= sq_idx_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.load_result) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_result) begin
            m_data_reg.best_index    <= 8'(best_idx_reg);
            m_data_reg.best_distance <= best_dist_reg;
        end
    end

    assign status.last_issue = cmd.issue && (rd_addr_reg == last_reg);
    assign status.busy       = rd_v_reg || sq_v_reg;
    assign status.out_busy   = m_valid_reg && !m_ready;

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// File: rtl/core/nearest_palette_color_match_unit.sv
// Top level of the nearest palette color match unit: squared-RGB nearest entry search.
// A write word is stored at once; a pixel word gives its result after a search over N entries,
// N being the clamped palette_count, and the input reopens as the result word appears.
// Throughput is set by the single palette memory read port, which yields one entry per cycle.
// Reset (aresetn, synchronous, active low) clears control state and sets palette_count to 256;
// the palette contents are undefined until written and need no clearing pass.
module nearest_palette_color_match_unit #(
    parameter int PALETTE_DEPTH = 256
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  npcm_pkg::in_word_t                s_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output npcm_pkg::out_word_t               m_data,
    input  logic                              cfg_wr_en,
    input  logic [npcm_pkg::CFG_W-1:0]        cfg_wr_data
);

    // The palette_count register. The user must write it only while the unit is idle, which the
    // block itself does not enforce, so the datapath can sample it when a search starts without any shadow copy.
    logic [npcm_pkg::CFG_W-1:0] palette_count_reg;

    // Command and status bundles between the controller and the datapath.
    npcm_pkg::cmd_t    cmd;
    npcm_pkg::status_t status;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            palette_count_reg <= npcm_pkg::CFG_W'(256);
        end else if (cfg_wr_en) begin
            palette_count_reg <= cfg_wr_data;
        end
    end

    // The controller accepts one word at a time. A write word stores its entry in the
    // same cycle and leaves the unit ready. A pixel word starts a search that reads
    // entries zero through N - 1, then drains the distance pipeline and hands the best
    // match to the result register. The result register is separate from the search,
    // so write words keep flowing while a result waits for m_ready.
    npcm_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_kind  (s_data.kind),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // The datapath holds the palette memory, a registered read, a stage of three
    // squared differences, and a stage that adds them and keeps the smallest sum.
    npcm_datapath #(
        .PALETTE_DEPTH (PALETTE_DEPTH)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_data        (s_data),
        .palette_count (palette_count_reg),
        .cmd           (cmd),
        .status        (status),
        .m_ready       (m_ready),
        .m_valid       (m_valid),
        .m_data        (m_data)
    );

endmodule

// File: rtl/core/npcm_checker.sv
// Port-level checker of the nearest palette color match unit and its bind statement.
module npcm_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        s_valid,
    input logic                        s_ready,
    input npcm_pkg::in_word_t          s_data,
    input logic                        m_valid,
    input logic                        m_ready,
    input npcm_pkg::out_word_t         m_data
);

    // A stalled result word holds its value.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result word changed while stalled");

    // Reset leaves no result word pending.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // A pixel word starts a search, which blocks the input in the cycle after it is taken.
    a_quant_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_data.kind == npcm_pkg::KIND_QUANT) |=> !s_ready)
        else $error("input ready right after a pixel word");

    // A palette write completes at once and leaves the input open.
    a_write_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_data.kind == npcm_pkg::KIND_WRITE) |=> s_ready)
        else $error("input blocked after a palette write");

    // A new result appears only as the search finishes and the input reopens.
    a_result_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> s_ready)
        else $error("result appeared while the unit was still busy");

endmodule

bind nearest_palette_color_match_unit npcm_checker u_npcm_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
